/* design/sample_set_statistics_assert.svh */
// Assertion macros for the sample set statistics block.
`ifndef SAMPLE_SET_STATISTICS_ASSERT_SVH
`define SAMPLE_SET_STATISTICS_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SSST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ssst_pkg.sv */
// Shared constants and types for the sample set statistics block.
`timescale 1ns / 1ps
`default_nettype none
package ssst_pkg;
	localparam int SAMPLE_BITS  = 16;
	localparam int CAPACITY_DEF = 4096;
	localparam int IN_DATA_W    = 16;
	localparam int OUT_DATA_W   = 168;
	localparam int PCT_HIGH     = 19;
	// ceil(2^24 / 20): x / 20 as a multiply and shift for x below 2^21
	localparam int PCT_RCP      = 838861;
	localparam int PCT_RCP_SH   = 24;
	localparam int MEAN_SH      = 4;
	localparam int VAR_SH       = 8;
	localparam int NUM_PICKS    = 8;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	localparam logic [2:0] PK_MIN    = 3'd0;
	localparam logic [2:0] PK_MAX    = 3'd1;
	localparam logic [2:0] PK_MED_LO = 3'd2;
	localparam logic [2:0] PK_MED_HI = 3'd3;
	localparam logic [2:0] PK_LQ     = 3'd4;
	localparam logic [2:0] PK_UQ     = 3'd5;
	localparam logic [2:0] PK_LP     = 3'd6;
	localparam logic [2:0] PK_HP     = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WAIT,
		ST_START,
		ST_SORT_RD0,
		ST_SORT_RUN,
		ST_SORT_END,
		ST_ARITH_WAIT,
		ST_PICK,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		AR_IDLE,
		AR_MUL,
		AR_SQRT,
		AR_DIV,
		AR_DONE
	} ar_state_t;
endpackage
`default_nettype wire

/* design/ssst_store.sv */
// Sample memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ssst_store import ssst_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int AW    = 12
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [SAMPLE_BITS-1:0] wdata,
	input  logic [AW-1:0]          raddr,
	output logic [SAMPLE_BITS-1:0] rdata
);
	logic [SAMPLE_BITS-1:0] mem_q [DEPTH];
	logic [SAMPLE_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* design/ssst_arith.sv */
// Iterative arithmetic: shift-add multiply, bitwise square root, restoring divide.
`timescale 1ns / 1ps
`default_nettype none
module ssst_arith import ssst_pkg::*; #(
	parameter int CW    = 13,
	parameter int SUM_W = 29,
	parameter int SQ_W  = 45
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CW-1:0]    n,
	input  logic [SUM_W-1:0] sum,
	input  logic [SQ_W-1:0]  sumsq,
	output logic             done,
	output logic [19:0]      mean_q4,
	output logic [18:0]      std_dev_q4,
	output logic [CW-1:0]    low_idx,
	output logic [CW-1:0]    high_idx
);
	localparam int SPR_W0 = CW + SQ_W + VAR_SH;
	localparam int SPR_W  = SPR_W0 + (SPR_W0 % 2);
	localparam int RTW    = SPR_W / 2;
	localparam int HX_W   = CW + 5;
	localparam int PW     = HX_W + 20;
	localparam int DVA    = (SUM_W + MEAN_SH > RTW) ? SUM_W + MEAN_SH : RTW;
	localparam int DVW    = (DVA > HX_W) ? DVA : HX_W;
	localparam int DSW    = (CW > 5) ? CW : 5;
	localparam int ITM    = (SPR_W > DVW) ? SPR_W : DVW;
	localparam int ITW    = $clog2(ITM + 1);

	ar_state_t state_q, state_d;

	logic [ITW-1:0]   cnt_q;
	logic [1:0]       phase_q;
	logic [SPR_W-1:0] acc_q, mcand_q, v_q, res_q, bit_q;
	logic [SUM_W-1:0] mplier_q;
	logic [DVW-1:0]   dvd_q;
	logic [DSW-1:0]   rem_q, dsr_q;
	logic [19:0]      mean_q;
	logic [18:0]      std_q;
	logic [CW-1:0]    lo_q, hi_q;

	logic [SPR_W-1:0] addend, acc_n, sq_t, res_n, v_n;
	logic             sq_ge;
	logic [DSW:0]     rn, rsub;
	logic             dv_ge;
	logic [DVW-1:0]   quo;
	logic [HX_W-1:0]  n19;
	logic [PW-1:0]    lo_prod, hi_prod;
	logic             last;

	assign last    = (cnt_q == ITW'(1));
	assign addend  = mplier_q[0] ? mcand_q : '0;
	assign acc_n   = phase_q[0] ? (acc_q - addend) : (acc_q + addend);
	assign sq_t    = res_q + bit_q;
	assign sq_ge   = (v_q >= sq_t);
	assign v_n     = sq_ge ? (v_q - sq_t) : v_q;
	assign res_n   = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
	assign rn      = {rem_q, dvd_q[DVW-1]};
	assign dv_ge   = (rn >= {1'b0, dsr_q});
	assign rsub    = rn - {1'b0, dsr_q};
	assign quo     = {dvd_q[DVW-2:0], dv_ge};
	assign n19     = HX_W'(PCT_HIGH) * HX_W'(n);
	assign lo_prod = PW'(n) * PW'(PCT_RCP);
	assign hi_prod = PW'(n19) * PW'(PCT_RCP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			AR_IDLE, AR_DONE: begin
				if (start) state_d = AR_MUL;
			end
			AR_MUL: begin
				if (last && phase_q == 2'd1) state_d = AR_SQRT;
			end
			AR_SQRT: begin
				if (last) state_d = AR_DIV;
			end
			AR_DIV: begin
				if (last && phase_q == 2'd1) state_d = AR_DONE;
			end
			default: state_d = AR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			phase_q <= '0;
		end else begin
			case (state_q)
				AR_IDLE, AR_DONE: begin
					if (start) begin
						cnt_q   <= ITW'(CW);
						phase_q <= 2'd0;
					end
				end
				AR_MUL: begin
					if (!last) begin
						cnt_q <= cnt_q - ITW'(1);
					end else if (phase_q == 2'd0) begin
						cnt_q   <= ITW'(SUM_W);
						phase_q <= 2'd1;
					end else begin
						cnt_q <= ITW'(RTW);
					end
				end
				AR_SQRT: begin
					if (!last) begin
						cnt_q <= cnt_q - ITW'(1);
					end else begin
						cnt_q   <= ITW'(DVW);
						phase_q <= 2'd0;
					end
				end
				AR_DIV: begin
					if (!last) begin
						cnt_q <= cnt_q - ITW'(1);
					end else begin
						cnt_q   <= ITW'(DVW);
						phase_q <= phase_q + 2'd1;
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			AR_IDLE, AR_DONE: begin
				if (start) begin
					acc_q    <= '0;
					mcand_q  <= SPR_W'(sumsq);
					mplier_q <= SUM_W'(n);
					lo_q     <= CW'(lo_prod >> PCT_RCP_SH);
					hi_q     <= CW'(hi_prod >> PCT_RCP_SH);
				end
			end
			AR_MUL: begin
				if (!last) begin
					acc_q    <= acc_n;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end else if (phase_q == 2'd0) begin
					// second pass subtracts sum*sum from n*sumsq
					acc_q    <= acc_n;
					mcand_q  <= SPR_W'(sum);
					mplier_q <= sum;
				end else begin
					v_q   <= acc_n << VAR_SH;
					res_q <= '0;
					bit_q <= SPR_W'(1) << (SPR_W - 2);
				end
			end
			AR_SQRT: begin
				v_q   <= v_n;
				res_q <= res_n;
				bit_q <= bit_q >> 2;
				if (last) begin
					dvd_q <= DVW'({sum, MEAN_SH'(0)});
					dsr_q <= DSW'(n);
					rem_q <= '0;
				end
			end
			AR_DIV: begin
				if (!last) begin
					rem_q <= dv_ge ? rsub[DSW-1:0] : rn[DSW-1:0];
					dvd_q <= quo;
				end else begin
					rem_q <= '0;
					case (phase_q)
						2'd0: begin
							mean_q <= quo[19:0];
							dvd_q  <= DVW'(res_q[RTW-1:0]);
							dsr_q  <= DSW'(n);
						end
						default: std_q <= quo[18:0];
					endcase
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign done       = (state_q == AR_DONE);
	assign mean_q4    = mean_q;
	assign std_dev_q4 = std_q;
	assign low_idx    = lo_q;
	assign high_idx   = hi_q;
endmodule
`default_nettype wire

/* design/sample_set_statistics.sv */
// Sample set statistics: load samples, then sort in memory and report order statistics.
// Load: one sample per cycle, s_tready high whenever the block is idle.
// Finish: setup, then bubble passes over the memory (the sort stops after a pass
// in which no swap occurs), then the picks and the output.
// Mean and deviation run alongside the sort on a bit-serial unit.
// Reset clears the count, sums, drop flag and handshakes; the sample memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sample_set_statistics import ssst_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // sample
	input  logic                  s_tuser,  // action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// minimum, maximum, mean_q4, std_dev_q4, median_doubled, lower_quartile,
	// upper_quartile, low_percentile, high_percentile, set_size, dropped, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata
);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SUM_W = SAMPLE_BITS + CW;
	localparam int SQ_W  = 2 * SAMPLE_BITS + CW;

	state_t state_q, state_d;

	logic [CW-1:0]            cnt_q, len_q, proc_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SQ_W-1:0]          sumsq_q;
	logic                     ovf_q, swap_q, sqv_s1;
	logic [2*SAMPLE_BITS-1:0] sq_s1;
	logic [SAMPLE_BITS-1:0]   carry_q;
	logic [SAMPLE_BITS-1:0]   slot_q [NUM_PICKS];
	logic [3:0]               pick_q;
	logic                     m_tvalid_q;
	logic [OUT_DATA_W-1:0]    m_tdata_q;

	logic                   accept, full, load_ok, load_full, out_fire, ar_start, ar_done;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [SAMPLE_BITS-1:0] mem_wdata, rdata, x;
	logic [CW-1:0]          proc_m1, proc_p1, len_m1, half, pick_idx, lo_idx, hi_idx;
	logic [CW+1:0]          n3;
	logic [3:0]             pick_m1;
	logic [19:0]            mean_q4;
	logic [18:0]            std_q4;
	logic [SAMPLE_BITS:0]   median;
	logic [OUT_DATA_W-1:0]  out_data;

	assign x         = s_tdata[SAMPLE_BITS-1:0];
	assign accept    = s_tvalid && s_tready;
	assign full      = (cnt_q == CW'(CAPACITY));
	assign load_ok   = accept && (s_tuser == ACT_LOAD) && !full;
	assign load_full = accept && (s_tuser == ACT_LOAD) && full;
	assign out_fire  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign proc_m1   = proc_q - CW'(1);
	assign proc_p1   = proc_q + CW'(1);
	assign len_m1    = len_q - CW'(1);
	assign half      = cnt_q >> 1;
	assign n3        = (CW + 2)'(cnt_q) * (CW + 2)'(3);
	assign pick_m1   = pick_q - 4'd1;

	ssst_store #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	ssst_arith #(
		.CW   (CW),
		.SUM_W(SUM_W),
		.SQ_W (SQ_W)
	) u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ar_start),
		.n         (cnt_q),
		.sum       (sum_q),
		.sumsq     (sumsq_q),
		.done      (ar_done),
		.mean_q4   (mean_q4),
		.std_dev_q4(std_q4),
		.low_idx   (lo_idx),
		.high_idx  (hi_idx)
	);

	always_comb begin
		case (pick_q[2:0])
			PK_MIN:    pick_idx = '0;
			PK_MAX:    pick_idx = cnt_q - CW'(1);
			PK_MED_LO: pick_idx = cnt_q[0] ? half : half - CW'(1);
			PK_MED_HI: pick_idx = half;
			PK_LQ:     pick_idx = cnt_q >> 2;
			PK_UQ:     pick_idx = CW'(n3 >> 2);
			PK_LP:     pick_idx = lo_idx;
			PK_HP:     pick_idx = hi_idx;
			default:   pick_idx = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ar_start  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = x;
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				mem_we   = load_ok;
				if (accept && s_tuser == ACT_FINISH) state_d = ST_WAIT;
			end
			ST_WAIT: state_d = ST_START;
			ST_START: begin
				if (cnt_q == '0) begin
					state_d = ST_OUT;
				end else begin
					ar_start = 1'b1;
					state_d  = (cnt_q < CW'(2)) ? ST_ARITH_WAIT : ST_SORT_RD0;
				end
			end
			ST_SORT_RD0: state_d = ST_SORT_RUN;
			ST_SORT_RUN: begin
				mem_we    = (proc_q != '0);
				mem_waddr = proc_m1[AW-1:0];
				mem_wdata = (rdata < carry_q) ? rdata : carry_q;
				mem_raddr = proc_p1[AW-1:0];
				if (proc_q == len_m1) state_d = ST_SORT_END;
			end
			ST_SORT_END: begin
				mem_we    = 1'b1;
				mem_waddr = len_m1[AW-1:0];
				mem_wdata = carry_q;
				state_d   = (!swap_q || len_q == CW'(2)) ? ST_ARITH_WAIT : ST_SORT_RD0;
			end
			ST_ARITH_WAIT: begin
				if (ar_done) state_d = ST_PICK;
			end
			ST_PICK: begin
				mem_raddr = pick_idx[AW-1:0];
				if (pick_q == 4'(NUM_PICKS)) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			sum_q      <= '0;
			sumsq_q    <= '0;
			ovf_q      <= 1'b0;
			sqv_s1     <= 1'b0;
			len_q      <= '0;
			proc_q     <= '0;
			swap_q     <= 1'b0;
			pick_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			sqv_s1 <= load_ok;
			if (load_ok) begin
				cnt_q <= cnt_q + CW'(1);
				sum_q <= sum_q + SUM_W'(x);
			end
			if (load_full) ovf_q <= 1'b1;
			if (sqv_s1) sumsq_q <= sumsq_q + SQ_W'(sq_s1);
			case (state_q)
				ST_START:      len_q <= cnt_q;
				ST_SORT_RD0: begin
					proc_q <= '0;
					swap_q <= 1'b0;
				end
				ST_SORT_RUN: begin
					proc_q <= proc_p1;
					if (proc_q != '0 && rdata < carry_q) swap_q <= 1'b1;
				end
				ST_SORT_END:   len_q  <= len_m1;
				ST_ARITH_WAIT: pick_q <= '0;
				ST_PICK:       pick_q <= pick_q + 4'd1;
				default:       pick_q <= pick_q;
			endcase
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			if (out_fire) begin
				m_tvalid_q <= 1'b1;
				cnt_q      <= '0;
				sum_q      <= '0;
				sumsq_q    <= '0;
				ovf_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			sq_s1 <= (2 * SAMPLE_BITS)'(x) * (2 * SAMPLE_BITS)'(x);
		end
		if (state_q == ST_SORT_RUN) begin
			carry_q <= (proc_q == '0 || rdata > carry_q) ? rdata : carry_q;
		end
		if (state_q == ST_PICK && pick_q != '0) begin
			slot_q[pick_m1[2:0]] <= rdata;
		end
		if (out_fire) begin
			m_tdata_q <= out_data;
		end
	end

	assign median = (SAMPLE_BITS + 1)'(slot_q[PK_MED_LO]) + (SAMPLE_BITS + 1)'(slot_q[PK_MED_HI]);

	always_comb begin
		if (cnt_q == '0) begin
			out_data = '0;
		end else begin
			out_data = {2'b00, ovf_q, 13'(cnt_q),
				slot_q[PK_HP], slot_q[PK_LP], slot_q[PK_UQ], slot_q[PK_LQ],
				median, std_q4, mean_q4, slot_q[PK_MAX], slot_q[PK_MIN]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`include "sample_set_statistics_assert.svh"

	`SSST_ASSERT_IMP(a_count_cap, 1'b1, cnt_q <= CW'(CAPACITY), "sample count beyond capacity")
	`SSST_ASSERT_IMP(a_pass_bound, state_q == ST_SORT_RUN, (len_q <= cnt_q) && (proc_q < len_q), "sort pass index out of range")
	`SSST_ASSERT_IMP(a_out_src, $rose(m_tvalid_q), $past(state_q) == ST_OUT, "result raised outside output state")
	`SSST_ASSERT_NXT(a_set_clear, out_fire, (cnt_q == '0) && (sum_q == '0) && !ovf_q, "set not cleared after result")
endmodule
`default_nettype wire
